[sv/base64_stream_encoder_top_macros.svh]
// assertion macros for the base64 stream encoder
`ifndef BASE64_STREAM_ENCODER_TOP_MACROS_SVH
`define BASE64_STREAM_ENCODER_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk_i, off during reset
`define B64E_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b64e assertion failed");
// next-cycle implication, sampled on clk_i, off during reset
`define B64E_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b64e assertion failed");
`else
`define B64E_ASSERT_NOW(name, ante, cons)
`define B64E_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[sv/b64e_pkg.sv]
`timescale 1ns / 1ps
package b64e_pkg;

  // default depth of the job queue between front and back
  localparam int unsigned QueueDepth = 2;

  // padding character '='
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  // output item
  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       message_end;
  } out_item_t;

  // one byte's work: two sextets, index of its last character, final flag
  typedef struct packed {
    logic [5:0] sextet0;
    logic [5:0] sextet1;
    logic [1:0] last_idx;
    logic       fin;
  } job_t;

  // standard alphabet lookup
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return w + 8'd65;
    end else if (v < 6'd52) begin
      return w + 8'd71;
    end else if (v < 6'd62) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

[sv/b64e_front.sv]
`timescale 1ns / 1ps
module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  b64e_pkg::in_item_t in_item_i,
  output logic              job_wr_o,
  output b64e_pkg::job_t    job_o
);

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic [7:0] b;
  logic       fin;
  logic       accept;

  assign accept   = push_i && !full_i;
  assign job_wr_o = accept;
  assign b        = in_item_i.data_byte;
  assign fin      = in_item_i.final_byte;

  // split the byte into sextets according to the group position
  always_comb begin
    job_o     = '0;
    job_o.fin = fin;
    phase_d   = phase_q;
    left_d    = left_q;
    case (phase_q)
      PH_SECOND: begin
        job_o.sextet0  = {left_q[1:0], b[7:4]};
        job_o.sextet1  = {b[3:0], 2'b00};
        job_o.last_idx = fin ? 2'd2 : 2'd0;
        phase_d        = PH_THIRD;
        left_d         = b[3:0];
      end
      PH_THIRD: begin
        job_o.sextet0  = {left_q, b[7:6]};
        job_o.sextet1  = b[5:0];
        job_o.last_idx = 2'd1;
        phase_d        = PH_START;
        left_d         = 4'd0;
      end
      default: begin
        job_o.sextet0  = b[7:2];
        job_o.sextet1  = {b[1:0], 4'b0000};
        job_o.last_idx = fin ? 2'd3 : 2'd0;
        phase_d        = PH_SECOND;
        left_d         = {2'b00, b[1:0]};
      end
    endcase
    if (fin) begin
      phase_d = PH_START;
      left_d  = 4'd0;
    end
  end

  // group position and leftover bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      left_q  <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

[sv/b64e_fifo.sv]
`timescale 1ns / 1ps
module b64e_fifo #(
  parameter int unsigned Depth = b64e_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  b64e_pkg::job_t wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output b64e_pkg::job_t rd_data_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

  b64e_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[sv/b64e_back.sv]
`timescale 1ns / 1ps
module b64e_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_empty_i,
  input  b64e_pkg::job_t      job_i,
  output logic                job_rd_o,
  input  logic                pop_i,
  output logic                empty_o,
  output b64e_pkg::out_item_t out_item_o
);

  localparam logic [1:0] IDX_FIRST  = 2'd0;
  localparam logic [1:0] IDX_SECOND = 2'd1;

  b64e_pkg::job_t      cur_q;
  logic                cur_valid_q, cur_valid_d;
  logic [1:0]          idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  b64e_pkg::out_item_t out_q, out_d;
  logic                is_last;
  logic                out_load;
  logic                out_take;

  assign is_last  = (idx_q == cur_q.last_idx);
  assign out_take = pop_i && out_valid_q;
  assign out_load = cur_valid_q && (!out_valid_q || out_take);
  assign job_rd_o = !job_empty_i && (!cur_valid_q || (out_load && is_last));

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  // character for the current position of the job
  always_comb begin
    case (idx_q)
      IDX_FIRST:  out_d.out_char = b64e_pkg::sextet_char(cur_q.sextet0);
      IDX_SECOND: out_d.out_char = b64e_pkg::sextet_char(cur_q.sextet1);
      default:    out_d.out_char = b64e_pkg::PAD_CHAR;
    endcase
    out_d.run_last    = is_last;
    out_d.message_end = is_last && cur_q.fin;
  end

  // next control state
  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (job_rd_o) begin
      cur_valid_d = 1'b1;
      idx_d       = IDX_FIRST;
    end else if (out_load) begin
      idx_d = idx_q + 1'b1;
      if (is_last) begin
        cur_valid_d = 1'b0;
      end
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  // job and output payload
  always_ff @(posedge clk_i) begin
    if (job_rd_o) begin
      cur_q <= job_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= IDX_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[sv/base64_stream_encoder_top.sv]
`timescale 1ns / 1ps
// a byte goes through the job queue, the job register and the output register
// throughput: one character per cycle through the output register while pop is held;
//   a byte makes one or two characters, up to four for a final byte starting a group
// a job queue of QueueDepth entries lets the input run ahead of the output
// reset (rst_ni low, asynchronous) empties the queue and output, and restarts the group
`include "base64_stream_encoder_top_macros.svh"
module base64_stream_encoder_top #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  b64e_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output b64e_pkg::out_item_t out_item_o
);

  logic           job_wr;
  b64e_pkg::job_t job_wr_data;
  logic           job_full;
  logic           job_rd;
  b64e_pkg::job_t job_rd_data;
  logic           job_empty;

  assign full = job_full;

  // input side: group tracking
  b64e_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_i    (job_full),
    .in_item_i (in_item_i),
    .job_wr_o  (job_wr),
    .job_o     (job_wr_data)
  );

  // job queue
  b64e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_wr),
    .wr_data_i (job_wr_data),
    .full_o    (job_full),
    .rd_i      (job_rd),
    .rd_data_o (job_rd_data),
    .empty_o   (job_empty)
  );

  // output side: one character per cycle while pop is held
  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_rd_data),
    .job_rd_o    (job_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

  // queue never overrun or underrun
  `B64E_ASSERT_NOW(a_no_overrun, job_wr, !job_full)
  `B64E_ASSERT_NOW(a_no_underrun, job_rd, !job_empty)
  // a final byte always yields at least two characters
  `B64E_ASSERT_NOW(a_final_two, job_wr && job_wr_data.fin, job_wr_data.last_idx != 2'd0)
  // a taken item leaves the queue non-empty next cycle
  `B64E_ASSERT_NEXT(a_queued, job_wr && !job_rd, !job_empty)

endmodule
